FILE: src/arpc_pkg.sv
// Shared types and constants of the ARP binding cache with aging.
package arpc_pkg;

  // Number of binding cells in the chain
  localparam int DEPTH = 16;
  // Width of a counter that holds 0 .. DEPTH
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam int IP_W      = 32;
  localparam int MAC_W     = 48;
  localparam int AGE_W     = 4;
  localparam int MODE_W    = 2;
  localparam int ECOUNT_W  = 5;

  localparam logic [AGE_W-1:0] AGE_MAX         = 4'd15;
  localparam logic [AGE_W-1:0] AGE_LIMIT_RESET = 4'd14;

  // Request codes
  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_TICK   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  // One stored binding
  typedef struct packed {
    logic             valid;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
    logic [AGE_W-1:0] age;
  } entry_t;

  // Per-cell control from the sequencer
  typedef struct packed {
    logic shift;  // take the neighbor's entry
    logic load;   // take the broadcast entry (wins over shift)
  } cell_ctl_t;

endpackage

FILE: src/arpc_cell.sv
// One cell of the binding chain: holds an entry, loads the broadcast entry or shifts from its neighbor.
module arpc_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  arpc_pkg::cell_ctl_t ctl,
  input  arpc_pkg::entry_t   nb_i,
  input  arpc_pkg::entry_t   ld_i,
  output arpc_pkg::entry_t   q_o
);
  import arpc_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  // Load has priority over the shift from the upper neighbor
  always_comb begin
    entry_nxt = entry_r;
    if (ctl.load) begin
      entry_nxt = ld_i;
    end else if (ctl.shift) begin
      entry_nxt = nb_i;
    end
  end

  // Whole entry cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
    end else begin
      entry_r <= entry_nxt;
    end
  end

  assign q_o = entry_r;

endmodule

FILE: src/arp_cache_with_aging.sv
// Top level of the ARP binding cache with aging: sequencer and chain of cells.
//
// Input channel (in_valid / in_stall) carries one request: in_mode, in_ip_addr,
// in_mac_addr. Mode insert appends a binding at the tail with age zero, lookup
// returns the oldest matching binding, tick ages all bindings and drops those
// older than the age limit. Each request gives one result on the output channel
// (out_valid / out_stall): out_hit, out_found_mac, out_dropped, out_entry_count.
// Insert and the unused mode answer in the cycle after acceptance and can follow
// back to back while out_stall is low. Lookup and tick rotate the chain through
// its head cell one entry per cycle, comparing or aging each binding there and
// recirculating it into the tail; the result is registered once the output
// register is free. The chain returns to its original order after a lookup and
// keeps the order of survivors after a tick. The age limit is written through
// cfg_valid / cfg_ready / cfg_data, which is always ready; the user must make
// writes only while the block is idle, which the block does not enforce. Reset
// (rst_n low, synchronous) empties the cache, sets the age limit to 14 and drops
// any pending result. While out_stall is high the result holds; a new request is
// taken only once the output register is free or being drained.
module arp_cache_with_aging (
  input  logic                        clk,
  input  logic                        rst_n,
  // request channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [arpc_pkg::MODE_W-1:0] in_mode,
  input  logic [arpc_pkg::IP_W-1:0]   in_ip_addr,
  input  logic [arpc_pkg::MAC_W-1:0]  in_mac_addr,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_hit,
  output logic [arpc_pkg::MAC_W-1:0]  out_found_mac,
  output logic                        out_dropped,
  output logic [arpc_pkg::ECOUNT_W-1:0] out_entry_count,
  // configuration
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [arpc_pkg::AGE_W-1:0]  cfg_data
);
  import arpc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  steps_r, steps_nxt;
  logic              is_tick_r, is_tick_nxt;
  logic [IP_W-1:0]   key_r, key_nxt;
  logic              hit_r, hit_nxt;
  logic [MAC_W-1:0]  mac_r, mac_nxt;
  logic [AGE_W-1:0]  age_limit_r;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_hit_r, out_hit_nxt;
  logic [MAC_W-1:0]     out_mac_r, out_mac_nxt;
  logic                 out_dropped_r, out_dropped_nxt;
  logic [ECOUNT_W-1:0]  out_count_r, out_count_nxt;

  entry_t    cell_q  [DEPTH];
  entry_t    cell_nb [DEPTH];
  cell_ctl_t cell_ctl[DEPTH];
  entry_t    ld_data;
  entry_t    head;
  logic      shift_en;
  logic      load_en;
  logic [CNT_W-1:0] tgt;

  logic out_free;
  logic accept;
  logic step;
  logic survive;
  mode_t mode;

  assign mode     = mode_t'(in_mode);
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;
  assign step     = (state_r == ST_WALK) && (steps_r != '0);
  assign head     = cell_q[0];
  assign cfg_ready = 1'b1;

  // Sequencer: insert and the unused mode answer directly, lookup and tick rotate the chain
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    steps_nxt      = steps_r;
    is_tick_nxt    = is_tick_r;
    key_nxt        = key_r;
    hit_nxt        = hit_r;
    mac_nxt        = mac_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_hit_nxt    = out_hit_r;
    out_mac_nxt    = out_mac_r;
    out_dropped_nxt = out_dropped_r;
    out_count_nxt  = out_count_r;
    shift_en       = 1'b0;
    load_en        = 1'b0;
    tgt            = count_r;
    survive        = 1'b1;
    ld_data.valid  = 1'b1;
    ld_data.ip     = head.ip;
    ld_data.mac    = head.mac;
    ld_data.age    = head.age;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          key_nxt     = in_ip_addr;
          hit_nxt     = 1'b0;
          mac_nxt     = '0;
          steps_nxt   = count_r;
          out_hit_nxt = 1'b0;
          out_mac_nxt = '0;
          out_dropped_nxt = 1'b0;
          unique case (mode)
            MODE_INSERT: begin
              ld_data.ip  = in_ip_addr;
              ld_data.mac = in_mac_addr;
              ld_data.age = '0;
              if (count_r == CNT_W'(DEPTH)) begin
                out_dropped_nxt = 1'b1;
                out_count_nxt   = ECOUNT_W'(count_r);
              end else begin
                load_en       = 1'b1;
                count_nxt     = count_r + 1'b1;
                out_count_nxt = ECOUNT_W'(count_r + 1'b1);
              end
              out_valid_nxt = 1'b1;
            end
            MODE_LOOKUP: begin
              is_tick_nxt = 1'b0;
              state_nxt   = ST_WALK;
            end
            MODE_TICK: begin
              is_tick_nxt = 1'b1;
              state_nxt   = ST_WALK;
            end
            default: begin
              out_count_nxt = ECOUNT_W'(count_r);
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_WALK: begin
        if (step) begin
          // Pop the head, recirculate it into the current tail cell
          shift_en  = 1'b1;
          load_en   = 1'b1;
          tgt       = count_r - 1'b1;
          steps_nxt = steps_r - 1'b1;
          if (is_tick_r) begin
            survive       = (head.age <= age_limit_r);
            ld_data.valid = survive;
            ld_data.age   = (head.age == AGE_MAX) ? AGE_MAX : head.age + 1'b1;
            if (!survive) begin
              count_nxt = count_r - 1'b1;
            end
          end else if (!hit_r && (head.ip == key_r)) begin
            hit_nxt = 1'b1;
            mac_nxt = head.mac;
          end
        end else if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_hit_nxt     = hit_r;
          out_mac_nxt     = mac_r;
          out_dropped_nxt = 1'b0;
          out_count_nxt   = ECOUNT_W'(count_r);
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Chain of cells; the top cell shifts in an empty entry
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_last
      assign cell_nb[i] = '0;
    end else begin : g_mid
      assign cell_nb[i] = cell_q[i+1];
    end
    assign cell_ctl[i].shift = shift_en;
    assign cell_ctl[i].load  = load_en && (tgt == CNT_W'(i));

    arpc_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (cell_ctl[i]),
      .nb_i  (cell_nb[i]),
      .ld_i  (ld_data),
      .q_o   (cell_q[i])
    );
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      steps_r     <= '0;
      out_valid_r <= 1'b0;
      age_limit_r <= AGE_LIMIT_RESET;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      steps_r     <= steps_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        age_limit_r <= cfg_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    is_tick_r     <= is_tick_nxt;
    key_r         <= key_nxt;
    hit_r         <= hit_nxt;
    mac_r         <= mac_nxt;
    out_hit_r     <= out_hit_nxt;
    out_mac_r     <= out_mac_nxt;
    out_dropped_r <= out_dropped_nxt;
    out_count_r   <= out_count_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_found_mac   = out_mac_r;
  assign out_dropped     = out_dropped_r;
  assign out_entry_count = out_count_r;

endmodule

FILE: tb/arp_cache_checker.sv
// Checker for the ARP binding cache: shadow cache, result prediction and comparison.
`timescale 1ns / 100ps

module arp_cache_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [arpc_pkg::MODE_W-1:0]   in_mode,
  input  logic [arpc_pkg::IP_W-1:0]     in_ip_addr,
  input  logic [arpc_pkg::MAC_W-1:0]    in_mac_addr,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          out_hit,
  input  logic [arpc_pkg::MAC_W-1:0]    out_found_mac,
  input  logic                          out_dropped,
  input  logic [arpc_pkg::ECOUNT_W-1:0] out_entry_count,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [arpc_pkg::AGE_W-1:0]    cfg_data,
  output int                            fail_count,
  output int                            pending,
  output int                            results_checked,
  output int                            lookup_hits,
  output int                            inserts_dropped
);
  import arpc_pkg::*;

  typedef struct packed {
    logic                hit;
    logic [MAC_W-1:0]    mac;
    logic                dropped;
    logic [ECOUNT_W-1:0] count;
  } arp_result_t;

  // Shadow of the cache: bindings packed from slot 0, oldest first
  entry_t           shadow_tbl[DEPTH];
  int               binding_count;
  logic [AGE_W-1:0] shadow_limit;

  arp_result_t awaited_results[$];
  int          n_fail;
  int          n_checked;
  int          n_hits;
  int          n_drops;

  // One line per mismatch, and count it
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] arp cache mismatch, %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    n_fail++;
  endtask

  // Apply one request to the shadow cache and return the result it must give
  function automatic arp_result_t cache_apply(input mode_t mode, input logic [IP_W-1:0] ip,
                                              input logic [MAC_W-1:0] mac);
    arp_result_t r;
    int          kept;
    r = '0;
    case (mode)
      MODE_INSERT: begin
        if (binding_count >= DEPTH) begin
          r.dropped = 1'b1;
        end else begin
          shadow_tbl[binding_count].valid = 1'b1;
          shadow_tbl[binding_count].ip    = ip;
          shadow_tbl[binding_count].mac   = mac;
          shadow_tbl[binding_count].age   = '0;
          binding_count++;
        end
      end
      MODE_LOOKUP: begin
        // oldest match wins
        for (int i = 0; i < DEPTH; i++) begin
          if (!r.hit && shadow_tbl[i].valid && shadow_tbl[i].ip == ip) begin
            r.hit = 1'b1;
            r.mac = shadow_tbl[i].mac;
          end
        end
      end
      MODE_TICK: begin
        // drop stale bindings, compact survivors in order, age them (saturating)
        kept = 0;
        for (int i = 0; i < DEPTH; i++) begin
          if (shadow_tbl[i].valid && shadow_tbl[i].age <= shadow_limit) begin
            shadow_tbl[kept] = shadow_tbl[i];
            if (shadow_tbl[kept].age != AGE_MAX) shadow_tbl[kept].age++;
            kept++;
          end
        end
        for (int i = kept; i < DEPTH; i++) shadow_tbl[i] = '0;
        binding_count = kept;
      end
      default: ;
    endcase
    r.count = binding_count[ECOUNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    arp_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) shadow_tbl[i] = '0;
      binding_count = 0;
      shadow_limit  = AGE_LIMIT_RESET;
      awaited_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) shadow_limit = cfg_data;

      // result side first: it always belongs to an earlier request
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result with no request waiting", {59'd0, out_entry_count}, 64'd0);
        end else begin
          want = awaited_results.pop_front();
          n_checked++;
          if (out_hit != want.hit) report_mismatch("hit", 64'(out_hit), 64'(want.hit));
          if (out_found_mac != want.mac)
            report_mismatch("found_mac", 64'(out_found_mac), 64'(want.mac));
          if (out_dropped != want.dropped)
            report_mismatch("dropped", 64'(out_dropped), 64'(want.dropped));
          if (out_entry_count != want.count)
            report_mismatch("entry_count", 64'(out_entry_count), 64'(want.count));
          if (want.hit) n_hits++;
          if (want.dropped) n_drops++;
        end
      end

      if (in_valid && !in_stall)
        awaited_results.push_back(cache_apply(mode_t'(in_mode), in_ip_addr, in_mac_addr));
    end

    // publish after this edge's updates
    fail_count      <= n_fail;
    pending         <= awaited_results.size();
    results_checked <= n_checked;
    lookup_hits     <= n_hits;
    inserts_dropped <= n_drops;
  end

endmodule

FILE: tb/arp_cache_with_aging_tb.sv
// Testbench top of the ARP binding cache with aging: stimulus, idling and verdict.
`timescale 1ns / 100ps

module arp_cache_with_aging_tb;
  import arpc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 250;
  localparam int SETTLE_CYCLES  = DEPTH + 4;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [MODE_W-1:0]   in_mode;
  logic [IP_W-1:0]     in_ip_addr;
  logic [MAC_W-1:0]    in_mac_addr;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_hit;
  logic [MAC_W-1:0]    out_found_mac;
  logic                out_dropped;
  logic [ECOUNT_W-1:0] out_entry_count;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [AGE_W-1:0]    cfg_data;

  int fail_count;
  int pending;
  int results_checked;
  int lookup_hits;
  int inserts_dropped;

  bit               no_idle;
  int               idle_cycles;
  int               tick_pct;
  logic [IP_W-1:0]  ip_pool[8];
  logic [AGE_W-1:0] phase_limit[6];

  arp_cache_with_aging dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_ip_addr      (in_ip_addr),
    .in_mac_addr     (in_mac_addr),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_hit         (out_hit),
    .out_found_mac   (out_found_mac),
    .out_dropped     (out_dropped),
    .out_entry_count (out_entry_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  arp_cache_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_ip_addr      (in_ip_addr),
    .in_mac_addr     (in_mac_addr),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_hit         (out_hit),
    .out_found_mac   (out_found_mac),
    .out_dropped     (out_dropped),
    .out_entry_count (out_entry_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked),
    .lookup_hits     (lookup_hits),
    .inserts_dropped (inserts_dropped)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side stalls about 10% of cycles, except in the quiet phase
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !no_idle && ($urandom_range(99) < 10);
    end
  end

  // Watchdog: too long without any handshake ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("** arp_cache_with_aging: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Present one request, hold it until taken, then maybe leave a gap
  task automatic send_request(input mode_t mode, input logic [IP_W-1:0] ip,
                              input logic [MAC_W-1:0] mac);
    in_valid    <= 1'b1;
    in_mode     <= mode;
    in_ip_addr  <= ip;
    in_mac_addr <= mac;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!no_idle && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Hold off until every result is back and the block has settled
  task automatic drain_cache;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_age_limit(input logic [AGE_W-1:0] limit);
    cfg_valid <= 1'b1;
    cfg_data  <= limit;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [MAC_W-1:0] rand_mac;
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return bits[MAC_W-1:0];
  endfunction

  // Mostly addresses from a small pool so lookups hit and duplicates pile up
  function automatic logic [IP_W-1:0] rand_ip;
    if ($urandom_range(99) < 75) return ip_pool[$urandom_range(7)];
    return $urandom;
  endfunction

  task automatic send_random_request;
    int    r;
    mode_t mode;
    r = $urandom_range(99);
    if (r < 5) mode = MODE_NONE;
    else if (r < 5 + tick_pct) mode = MODE_TICK;
    else if (r < 5 + tick_pct + (95 - tick_pct) / 2) mode = MODE_INSERT;
    else mode = MODE_LOOKUP;
    send_request(mode, rand_ip(), rand_mac());
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_mode     = MODE_NONE;
    in_ip_addr  = '0;
    in_mac_addr = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    no_idle     = 1'b0;
    tick_pct    = 20;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty cache, unused mode, extremes, duplicates, full store
    send_request(MODE_LOOKUP, 32'h0, 48'h0);
    send_request(MODE_TICK, 32'h0, 48'h0);
    send_request(MODE_NONE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_request(MODE_INSERT, 32'h0, 48'h0);
    send_request(MODE_INSERT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_request(MODE_INSERT, 32'hFFFF_FFFF, 48'h1234_5678_9ABC);
    send_request(MODE_LOOKUP, 32'hFFFF_FFFF, 48'h0);
    send_request(MODE_LOOKUP, 32'h0, 48'hFFFF_FFFF_FFFF);
    send_request(MODE_LOOKUP, 32'h0A00_0001, 48'h0);
    send_request(MODE_NONE, 32'h0, 48'h0);
    // 13 fill the store, the last two are dropped
    for (int k = 0; k < 15; k++) send_request(MODE_INSERT, 32'h0A00_0000 + k, rand_mac());
    send_request(MODE_LOOKUP, 32'h0A00_000C, 48'h0);
    send_request(MODE_TICK, 32'h0, 48'h0);
    send_request(MODE_LOOKUP, 32'hFFFF_FFFF, 48'h0);

    // Random phases, one per age limit; extremes included
    phase_limit[0] = 4'd0;
    phase_limit[1] = 4'd15;
    phase_limit[2] = 4'd1;
    phase_limit[3] = 4'd7;
    phase_limit[4] = 4'($urandom_range(2, 13));
    phase_limit[5] = 4'd14;
    for (int p = 0; p < 6; p++) begin
      drain_cache();
      write_age_limit(phase_limit[p]);
      ip_pool[0] = 32'h0;
      ip_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < 8; i++) ip_pool[i] = $urandom;
      no_idle  = (p == 3);
      tick_pct = (phase_limit[p] >= 4'd14) ? 35 : 20;
      repeat (PHASE_ITEMS) send_random_request();
    end
    no_idle = 1'b0;

    drain_cache();
    $display("Checked %0d results: %0d lookup hits, %0d dropped inserts.",
             results_checked, lookup_hits, inserts_dropped);
    $display("Age limits 14 (reset), 0, 15, 1, 7, %0d and 14; one phase ran without stalls.",
             phase_limit[4]);
    if (fail_count == 0) begin
      $display("** arp_cache_with_aging: PASSED **");
    end else begin
      $display("** arp_cache_with_aging: FAILED **");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/arpc_pkg.sv
src/arpc_cell.sv
src/arp_cache_with_aging.sv
tb/arp_cache_checker.sv
tb/arp_cache_with_aging_tb.sv
